// ===== src/daq_pkg.sv =====
// Shared types and codes for the deduplicating address queue.
`default_nettype none
package daq_pkg;

   localparam int ADDR_W = 48;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_DELETE  = 2'd2,
      OP_PEEK    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   address_in;
   } daq_req_type;

   typedef struct packed {
      status_type          status;
      logic [ADDR_W-1:0]   address_out;
      logic [OCC_W-1:0]    occupancy;
   } daq_rsp_type;

   // Commands broadcast to every cell of the chain.
   typedef struct packed {
      logic shift_all;   // dequeue: every cell takes its neighbor's entry
      logic delete_en;   // delete: cells at or after the match take their neighbor's entry
      logic enqueue_en;  // enqueue: the first empty cell loads the address
   } daq_cmd_type;

endpackage
`default_nettype wire

// ===== src/daq_cell.sv =====
// One storage cell of the queue chain: an entry, its valid bit and its compare.
`default_nettype none
module daq_cell
   import daq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire daq_cmd_type       cmd,
   input  wire logic [ADDR_W-1:0] address_in,
   input  wire logic              prev_valid,
   input  wire logic              hit_in,
   input  wire logic              next_valid,
   input  wire logic [ADDR_W-1:0] next_address,
   output logic                   valid,
   output logic [ADDR_W-1:0]      address,
   output logic                   match,
   output logic                   hit_out
);

   logic              valid_ff;
   logic              valid_in;
   logic [ADDR_W-1:0] entry_ff;
   logic [ADDR_W-1:0] entry_in;
   logic              shift;
   logic              load;

   assign match   = valid_ff && (entry_ff == address_in);
   assign hit_out = hit_in || match;

   // Take the neighbor's entry on a dequeue, or on a delete at or before this cell.
   assign shift = cmd.shift_all || (cmd.delete_en && hit_out);
   // Only the first empty cell takes a new address.
   assign load  = cmd.enqueue_en && !valid_ff && prev_valid;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (shift) begin
         valid_in = next_valid;
         entry_in = next_address;
      end else if (load) begin
         valid_in = 1'b1;
         entry_in = address_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign valid   = valid_ff;
   assign address = entry_ff;

endmodule
`default_nettype wire

// ===== src/dedup_address_queue_unit.sv =====
// Top level of the deduplicating address queue: cell chain, control and result register.
`default_nettype none
// The queue holds up to QUEUE_DEPTH distinct 48-bit addresses in arrival order,
// with the head in the first cell of a chain of identical cells. A command beat
// is taken at a rising edge where start is high and busy is low; busy is never
// raised, so one command can be taken in every cycle. Each command is enqueue,
// dequeue, delete by address or peek at the tail.
// All cells compare the command address against their entry in parallel, and a
// hit signal ripples down the chain so that every cell at or behind a deleted
// entry takes its neighbor's entry in the same edge. The longest path is that
// ripple through the chain plus the 48-bit compare in each cell.
// Exactly one result beat follows each command, in the cycle after it is taken,
// marked by rsp_strobe for a single cycle. The receiver cannot stall; the result
// register is refreshed by every command, and the state the next command sees
// already includes the previous one, so the throughput is one command a cycle.
// A synchronous reset empties the queue by clearing every valid bit and the
// occupancy counter; stored addresses are not cleared and are never read while
// their valid bit is low.
module dedup_address_queue_unit
   import daq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire daq_req_type req_data,
   output logic             rsp_strobe,
   output daq_rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [QUEUE_DEPTH-1:0] match_vec;
   logic [QUEUE_DEPTH:0]   hit_chain;
   logic [ADDR_W-1:0]      cell_address [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]   chain_valid;
   logic [ADDR_W-1:0]      chain_address [QUEUE_DEPTH+1];

   daq_cmd_type       cmd;
   logic              accept;
   logic              any_match;
   logic              is_empty;
   logic              is_full;
   logic [ADDR_W-1:0] tail_address;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_strobe_ff;
   daq_rsp_type       rsp_data_ff;
   daq_rsp_type       rsp_data_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign hit_chain[0]               = 1'b0;
   assign chain_valid[QUEUE_DEPTH]   = 1'b0;
   assign chain_address[QUEUE_DEPTH] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = valid_vec[i-1];
      end

      daq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .address_in   (req_data.address_in),
         .prev_valid   (prev_valid),
         .hit_in       (hit_chain[i]),
         .next_valid   (chain_valid[i+1]),
         .next_address (chain_address[i+1]),
         .valid        (valid_vec[i]),
         .address      (cell_address[i]),
         .match        (match_vec[i]),
         .hit_out      (hit_chain[i+1])
      );

      assign chain_valid[i]   = valid_vec[i];
      assign chain_address[i] = cell_address[i];
   end

   assign any_match = |match_vec;
   // Valid bits always form a prefix, so the first and last cells tell empty and full.
   assign is_empty  = !valid_vec[0];
   assign is_full   = valid_vec[QUEUE_DEPTH-1];

   // The tail is the one valid cell whose neighbor is empty.
   always_comb begin
      tail_address = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (valid_vec[i] && !chain_valid[i+1]) begin
            tail_address = tail_address | cell_address[i];
         end
      end
   end

   // Decode the command into cell controls, the result and the next count.
   always_comb begin
      cmd                     = '0;
      count_in                = count_ff;
      rsp_data_in.status      = ST_OK;
      rsp_data_in.address_out = '0;
      case (req_data.operation)
         OP_ENQUEUE: begin
            if (any_match) begin
               rsp_data_in.status = ST_DUPLICATE;
            end else if (is_full) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               cmd.enqueue_en = accept;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         OP_DEQUEUE: begin
            if (is_empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               cmd.shift_all           = accept;
               rsp_data_in.address_out = cell_address[0];
               count_in                = count_ff - CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (any_match) begin
               cmd.delete_en = accept;
               count_in      = count_ff - CNT_W'(1);
            end else begin
               rsp_data_in.status = ST_NOT_FOUND;
            end
         end
         OP_PEEK: begin
            if (is_empty) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               rsp_data_in.address_out = tail_address;
            end
         end
         default: begin
            rsp_data_in.status = ST_OK;
         end
      endcase
      // The occupancy field keeps the low bits of the count.
      rsp_data_in.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/daq_checker.sv =====
// Port-level checks for the deduplicating address queue, bound to the top level.
`default_nettype none
module daq_checker
   import daq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire daq_rsp_type rsp_data
);

   // Every accepted command beat produces a result beat in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("result beat missing after accepted command");

   // No result beat appears without a command beat in the cycle before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result beat without a command");

   // Only a successful dequeue or peek returns a nonzero address.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.address_out == '0))
      else $error("nonzero address on a failed command");

   // While the depth fits the occupancy field, the reported occupancy never exceeds the queue depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (QUEUE_DEPTH < 32)) |-> (int'(rsp_data.occupancy) <= QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   // An empty status always reports an empty queue.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ST_EMPTY) |-> (rsp_data.occupancy == '0))
      else $error("empty status with nonzero occupancy");

endmodule

bind dedup_address_queue_unit daq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_daq_checker (.*);
`default_nettype wire
